FILE: src/slfp_pkg.sv
// Shared types, constants and character codes of the scan list field parser.
// Used by slfp_front, slfp_fifo, slfp_back and scan_list_field_parser.
`default_nettype none

package slfp_pkg;

    // Table and field buffer sizes
    localparam int MAX_RECORDS = 16;
    localparam int FIELD_CHARS = 32;

    localparam int LINE_W = $clog2(MAX_RECORDS + 1);
    localparam int CNT_W  = $clog2(FIELD_CHARS + 1);
    localparam int ADDR_W = $clog2(FIELD_CHARS);
    localparam int REC_W  = 4;
    localparam int FLD_W  = 5;
    localparam int ZCNT_W = 12;
    localparam int BLK_W  = 2;
    localparam int SIG_W  = 16;
    localparam int ACC_W  = 17;
    localparam int PROD_W = 20;

    localparam logic [LINE_W-1:0] LINE_MAX   = LINE_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(FIELD_CHARS);
    localparam logic [ZCNT_W-1:0] ZCNT_SAT   = {ZCNT_W{1'b1}};
    localparam logic [ZCNT_W-1:0] TIMEOUT_RST = ZCNT_W'(1500);

    // Field index codes
    localparam logic [FLD_W-1:0] FIELD_NONE = 5'd31;
    localparam logic [FLD_W-1:0] FIELD_TOP  = 5'd30;
    localparam logic [FLD_W-1:0] FIELD_NAME = 5'd1;
    localparam logic [FLD_W-1:0] FIELD_SEC  = 5'd3;
    localparam logic [FLD_W-1:0] FIELD_SIG  = 5'd4;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_NAME   = 2'd1;
    localparam logic [1:0] KIND_SEC    = 2'd2;
    localparam logic [1:0] KIND_SIG    = 2'd3;

    // Signal value constants
    localparam logic signed [SIG_W-1:0] SIG_BLACKLIST = -16'sd2;
    localparam logic signed [SIG_W-1:0] SIG_POS_MAX   = 16'sd32767;
    localparam logic [ACC_W-1:0]        ACC_POS_MAX   = 17'd32767;
    localparam logic [ACC_W-1:0]        ACC_NEG_MAX   = 17'd32768;
    localparam logic [PROD_W-1:0]       ACC_SAT       = 20'd100000;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // Command queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [1:0] {
        OP_STATUS,
        OP_NAME,
        OP_SEC,
        OP_VALUE
    } t_op;

    // One job from the front to the back
    typedef struct packed {
        t_op              op;
        logic [REC_W-1:0] rec;
        logic             done;
        logic             ovf;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    // Field buffer write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_buf_wr;

    // Back to front status
    typedef struct packed {
        logic job_done;
    } t_bk_status;

endpackage

`default_nettype wire

FILE: src/scan_list_field_parser.sv
// Top level of the scan list field parser: front end, job queue, back end.
// Depends on slfp_pkg, slfp_front, slfp_fifo and slfp_back.
//
//   channel   | handshake           | payload
//   ----------+---------------------+------------------------------------------
//   input     | i_valid / o_ready   | i_ch
//   result    | o_valid / i_ready   | o_field_kind, o_record_index, o_text_char,
//             |                     | o_signal_value, o_last, o_done_res,
//             |                     | o_record_overflow
//   config    | i_cfg_wr_en         | i_cfg_wr_data (timeout_limit)
//
// The front end takes one byte per cycle while o_ready is high and turns it into
// one job; a status job is loaded into the result register once the back end
// has it and the result register is free. A string job is loaded, then streams
// one stored character per cycle while the result register is free, plus its
// terminator (and the blacklist value for a name), up to 34 results; a value job
// skips white space, takes an optional sign, reads its digits and emits one
// result. The field buffer has a single read port, and the front end holds
// o_ready low until such a job has emitted its last result. Reset is
// synchronous, active low, and needs no clearing pass. A stalled result register
// backs up into the two-entry job queue before the front end stops taking bytes.
`default_nettype none

module scan_list_field_parser (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [7:0]                      i_ch,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [slfp_pkg::ZCNT_W-1:0]     i_cfg_wr_data,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [1:0]                           o_field_kind,
    output logic [slfp_pkg::REC_W-1:0]           o_record_index,
    output logic [7:0]                           o_text_char,
    output logic signed [slfp_pkg::SIG_W-1:0]    o_signal_value,
    output logic                                 o_last,
    output logic                                 o_done_res,
    output logic                                 o_record_overflow
);

    // Jobs from front to back
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_valid;
    slfp_pkg::t_cmd        q_in;
    slfp_pkg::t_cmd        q_out;

    // Buffer writes and job completion
    slfp_pkg::t_buf_wr     buf_wr;
    slfp_pkg::t_bk_status  bk_status;

    // Classify each transaction and keep the record state
    slfp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_ch          (i_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_in),
        .o_buf_wr      (buf_wr),
        .i_bk_status   (bk_status)
    );

    // Decouple the two ends so each can stall on its own
    slfp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // Carry out jobs and drive the result transactions
    slfp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_buf_wr          (buf_wr),
        .i_q_valid         (q_valid),
        .i_q_data          (q_out),
        .o_q_pop           (q_pop),
        .o_bk_status       (bk_status),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_field_kind      (o_field_kind),
        .o_record_index    (o_record_index),
        .o_text_char       (o_text_char),
        .o_signal_value    (o_signal_value),
        .o_last            (o_last),
        .o_done_res        (o_done_res),
        .o_record_overflow (o_record_overflow)
    );

endmodule

`default_nettype wire

FILE: src/slfp_front.sv
// Front end: accepts bytes, keeps line/field/count state, writes the field buffer
// and classifies each byte into one job for the back end. Depends on slfp_pkg.
`default_nettype none

module slfp_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [7:0]                      i_ch,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [slfp_pkg::ZCNT_W-1:0]     i_cfg_wr_data,
    input  wire logic                            i_q_full,
    output logic                                 o_q_push,
    output slfp_pkg::t_cmd                       o_q_data,
    output slfp_pkg::t_buf_wr                    o_buf_wr,
    input  wire slfp_pkg::t_bk_status            i_bk_status
);

    logic [slfp_pkg::LINE_W-1:0] r_line, n_line;
    logic [slfp_pkg::FLD_W-1:0]  r_field, n_field;
    logic [slfp_pkg::CNT_W-1:0]  r_count, n_count;
    logic                        r_after, n_after;
    logic [slfp_pkg::BLK_W-1:0]  r_blank, n_blank;
    logic [slfp_pkg::ZCNT_W-1:0] r_zero, n_zero;
    logic [slfp_pkg::ZCNT_W-1:0] r_timeout;
    logic                        r_hold, n_hold;

    logic           accept;
    logic           done;
    logic           commit;
    logic [slfp_pkg::ZCNT_W-1:0] zinc;
    slfp_pkg::t_cmd    cmd;
    slfp_pkg::t_buf_wr wr;

    assign o_ready  = !r_hold && !i_q_full;
    assign accept   = i_valid && o_ready;
    assign o_q_push = accept;
    assign o_q_data = cmd;
    assign o_buf_wr = wr;

    always_comb begin
        n_line  = r_line;
        n_field = r_field;
        n_count = r_count;
        n_after = r_after;
        n_blank = r_blank;
        n_zero  = r_zero;
        n_hold  = r_hold;
        done    = 1'b0;
        commit  = 1'b0;
        zinc    = r_zero;
        wr      = '0;
        cmd     = '0;
        cmd.op  = slfp_pkg::OP_STATUS;

        // Release the buffer once the back end has read it out
        if (i_bk_status.job_done) begin
            n_hold = 1'b0;
        end

        if (accept) begin
            // Zero bytes count toward the timeout
            if (i_ch == slfp_pkg::CH_NUL) begin
                zinc   = (r_zero != slfp_pkg::ZCNT_SAT) ? r_zero + 1'b1 : r_zero;
                n_zero = zinc;
                if (zinc > r_timeout) begin
                    n_zero  = '0;
                    n_line  = '0;
                    n_count = '0;
                    n_field = '0;
                    n_blank = '0;
                    done    = 1'b1;
                end
            end

            priority if (i_ch == slfp_pkg::CH_COMMA) begin
                if (r_field == slfp_pkg::FIELD_NONE) begin
                    n_field = '0;
                end else if (r_field < slfp_pkg::FIELD_TOP) begin
                    n_field = r_field + 1'b1;
                end
                commit = 1'b1;
            end else if (i_ch == slfp_pkg::CH_LF) begin
                n_count = '0;
                n_field = slfp_pkg::FIELD_NONE;
            end else if (i_ch == slfp_pkg::CH_CR) begin
                if (r_after) begin
                    // Second blank CR ends the reply
                    if (r_blank != '0) begin
                        n_line  = '0;
                        n_count = '0;
                        n_field = '0;
                        n_blank = '0;
                        done    = 1'b1;
                    end else begin
                        n_blank = r_blank + 1'b1;
                    end
                end else begin
                    commit = 1'b1;
                end
            end else begin
                // Ordinary byte: store unless the buffer is full
                if (n_count < slfp_pkg::CNT_MAX) begin
                    wr.en   = 1'b1;
                    wr.addr = n_count[slfp_pkg::ADDR_W-1:0];
                    wr.data = i_ch;
                    n_count = n_count + 1'b1;
                end
                n_blank = '0;
            end
            n_after = (i_ch == slfp_pkg::CH_LF);

            cmd.rec  = slfp_pkg::REC_W'(n_line);
            cmd.done = done;
            cmd.cnt  = r_count;
            if (commit && (n_field == slfp_pkg::FIELD_NAME || n_field == slfp_pkg::FIELD_SEC
                           || n_field == slfp_pkg::FIELD_SIG)) begin
                if (n_line >= slfp_pkg::LINE_MAX) begin
                    cmd.ovf = 1'b1;
                end else if (n_field == slfp_pkg::FIELD_NAME) begin
                    cmd.op = slfp_pkg::OP_NAME;
                end else if (n_field == slfp_pkg::FIELD_SEC) begin
                    cmd.op = slfp_pkg::OP_SEC;
                end else begin
                    cmd.op = slfp_pkg::OP_VALUE;
                end
            end
            // Hold off new bytes while the back end reads the buffer
            if (cmd.op != slfp_pkg::OP_STATUS) begin
                n_hold = 1'b1;
            end

            if (i_ch == slfp_pkg::CH_COMMA) begin
                n_count = '0;
            end
            if (i_ch == slfp_pkg::CH_LF && n_line < slfp_pkg::LINE_MAX) begin
                n_line = n_line + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line    <= '0;
            r_field   <= slfp_pkg::FIELD_NONE;
            r_count   <= '0;
            r_after   <= 1'b0;
            r_blank   <= '0;
            r_zero    <= '0;
            r_timeout <= slfp_pkg::TIMEOUT_RST;
            r_hold    <= 1'b0;
        end else begin
            r_line  <= n_line;
            r_field <= n_field;
            r_count <= n_count;
            r_after <= n_after;
            r_blank <= n_blank;
            r_zero  <= n_zero;
            r_hold  <= n_hold;
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/slfp_fifo.sv
// Two-entry job queue between the front and back ends.
// Depends on slfp_pkg for the job type and depth.
`default_nettype none

module slfp_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire slfp_pkg::t_cmd    i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output slfp_pkg::t_cmd         o_data
);

    slfp_pkg::t_cmd               r_mem [slfp_pkg::Q_DEPTH];
    logic [slfp_pkg::Q_PTR_W-1:0] r_wp, r_rp;
    logic [slfp_pkg::Q_CNT_W-1:0] r_cnt;
    logic                         do_push, do_pop;

    assign o_full  = (r_cnt == slfp_pkg::Q_CNT_W'(slfp_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/slfp_back.sv
// Back end: holds the field buffer memory, streams strings out of it one
// character a cycle while the result register is free, parses the signal
// value and drives the result register. Depends on slfp_pkg.
`default_nettype none

module slfp_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire slfp_pkg::t_buf_wr               i_buf_wr,
    input  wire logic                            i_q_valid,
    input  wire slfp_pkg::t_cmd                  i_q_data,
    output logic                                 o_q_pop,
    output slfp_pkg::t_bk_status                 o_bk_status,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [1:0]                           o_field_kind,
    output logic [slfp_pkg::REC_W-1:0]           o_record_index,
    output logic [7:0]                           o_text_char,
    output logic signed [slfp_pkg::SIG_W-1:0]    o_signal_value,
    output logic                                 o_last,
    output logic                                 o_done_res,
    output logic                                 o_record_overflow
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STR,
        ST_SIG,
        ST_WS,
        ST_DIG
    } t_state;

    logic [7:0] r_buf_mem [slfp_pkg::FIELD_CHARS];
    logic [7:0] r_rd_data;

    t_state                      r_state, n_state;
    slfp_pkg::t_op               r_op, n_op;
    logic [slfp_pkg::REC_W-1:0]  r_rec, n_rec;
    logic [slfp_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [slfp_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic                        r_neg, n_neg;
    logic [slfp_pkg::ACC_W-1:0]  r_acc, n_acc;

    logic                                r_o_valid, n_o_valid;
    logic [1:0]                          r_o_kind, n_o_kind;
    logic [slfp_pkg::REC_W-1:0]          r_o_rec, n_o_rec;
    logic [7:0]                          r_o_char, n_o_char;
    logic signed [slfp_pkg::SIG_W-1:0]   r_o_sig, n_o_sig;
    logic                                r_o_last, n_o_last;
    logic                                r_o_done, n_o_done;
    logic                                r_o_ovf, n_o_ovf;

    logic                         out_free;
    logic                         in_range;
    logic                         is_digit;
    logic [slfp_pkg::PROD_W-1:0]  prod;
    logic [slfp_pkg::ACC_W-1:0]   mag;
    logic signed [slfp_pkg::SIG_W-1:0] final_sig;

    assign o_valid           = r_o_valid;
    assign o_field_kind      = r_o_kind;
    assign o_record_index    = r_o_rec;
    assign o_text_char       = r_o_char;
    assign o_signal_value    = r_o_sig;
    assign o_last            = r_o_last;
    assign o_done_res        = r_o_done;
    assign o_record_overflow = r_o_ovf;

    // Field buffer: one write port from the front, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_buf_wr.en) begin
            r_buf_mem[i_buf_wr.addr] <= i_buf_wr.data;
        end
        r_rd_data <= r_buf_mem[n_idx[slfp_pkg::ADDR_W-1:0]];
    end

    assign out_free = !r_o_valid || i_ready;
    assign in_range = (r_idx < r_cnt);
    assign is_digit = (r_rd_data >= slfp_pkg::CH_0) && (r_rd_data <= slfp_pkg::CH_9);
    assign prod     = slfp_pkg::PROD_W'(r_acc) * slfp_pkg::PROD_W'(10)
                    + slfp_pkg::PROD_W'(r_rd_data[3:0]);

    // Apply sign and saturate to 16 bits
    always_comb begin
        mag       = (r_acc > slfp_pkg::ACC_NEG_MAX) ? slfp_pkg::ACC_NEG_MAX : r_acc;
        final_sig = slfp_pkg::SIG_W'(~mag + 1'b1);
        if (!r_neg) begin
            final_sig = (r_acc > slfp_pkg::ACC_POS_MAX) ? slfp_pkg::SIG_POS_MAX
                                                        : slfp_pkg::SIG_W'(r_acc);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_rec     = r_rec;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_neg     = r_neg;
        n_acc     = r_acc;
        n_o_valid = r_o_valid && !i_ready;
        n_o_kind  = r_o_kind;
        n_o_rec   = r_o_rec;
        n_o_char  = r_o_char;
        n_o_sig   = r_o_sig;
        n_o_last  = r_o_last;
        n_o_done  = r_o_done;
        n_o_ovf   = r_o_ovf;
        o_q_pop   = 1'b0;
        o_bk_status.job_done = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_data.op == slfp_pkg::OP_STATUS) begin
                        // Status job: one result straight out
                        if (out_free) begin
                            o_q_pop   = 1'b1;
                            n_o_valid = 1'b1;
                            n_o_kind  = slfp_pkg::KIND_STATUS;
                            n_o_rec   = i_q_data.rec;
                            n_o_char  = '0;
                            n_o_sig   = '0;
                            n_o_last  = 1'b1;
                            n_o_done  = i_q_data.done;
                            n_o_ovf   = i_q_data.ovf;
                        end
                    end else begin
                        // Buffer job: load it and start reading at entry zero
                        o_q_pop = 1'b1;
                        n_op    = i_q_data.op;
                        n_rec   = i_q_data.rec;
                        n_cnt   = i_q_data.cnt;
                        n_idx   = '0;
                        n_neg   = 1'b0;
                        n_acc   = '0;
                        n_state = (i_q_data.op == slfp_pkg::OP_VALUE) ? ST_WS : ST_STR;
                    end
                end
            end
            ST_STR: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = (r_op == slfp_pkg::OP_NAME) ? slfp_pkg::KIND_NAME
                                                            : slfp_pkg::KIND_SEC;
                    n_o_rec   = r_rec;
                    n_o_sig   = '0;
                    n_o_done  = 1'b0;
                    n_o_ovf   = 1'b0;
                    if (in_range && r_rd_data != slfp_pkg::CH_NUL) begin
                        n_o_char = r_rd_data;
                        n_o_last = 1'b0;
                        n_idx    = r_idx + 1'b1;
                    end else begin
                        // Terminator; a name goes on to the blacklist value
                        n_o_char = slfp_pkg::CH_NUL;
                        n_o_last = (r_op == slfp_pkg::OP_SEC);
                        if (r_op == slfp_pkg::OP_SEC) begin
                            o_bk_status.job_done = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_SIG;
                        end
                    end
                end
            end
            ST_SIG: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = slfp_pkg::KIND_SIG;
                    n_o_rec   = r_rec;
                    n_o_char  = '0;
                    n_o_sig   = slfp_pkg::SIG_BLACKLIST;
                    n_o_last  = 1'b1;
                    n_o_done  = 1'b0;
                    n_o_ovf   = 1'b0;
                    o_bk_status.job_done = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_WS: begin
                // Skip white space, take an optional sign
                if (in_range && (r_rd_data == slfp_pkg::CH_SP || r_rd_data == slfp_pkg::CH_TAB
                                 || r_rd_data == slfp_pkg::CH_VT
                                 || r_rd_data == slfp_pkg::CH_FF)) begin
                    n_idx = r_idx + 1'b1;
                end else if (in_range && (r_rd_data == slfp_pkg::CH_MINUS
                                          || r_rd_data == slfp_pkg::CH_PLUS)) begin
                    n_neg   = (r_rd_data == slfp_pkg::CH_MINUS);
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_DIG;
                end else begin
                    n_state = ST_DIG;
                end
            end
            ST_DIG: begin
                if (in_range && is_digit) begin
                    n_acc = (prod > slfp_pkg::ACC_SAT) ? slfp_pkg::ACC_W'(slfp_pkg::ACC_SAT)
                                                       : slfp_pkg::ACC_W'(prod);
                    n_idx = r_idx + 1'b1;
                end else if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = slfp_pkg::KIND_SIG;
                    n_o_rec   = r_rec;
                    n_o_char  = '0;
                    n_o_sig   = final_sig;
                    n_o_last  = 1'b1;
                    n_o_done  = 1'b0;
                    n_o_ovf   = 1'b0;
                    o_bk_status.job_done = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_op     <= n_op;
        r_rec    <= n_rec;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_neg    <= n_neg;
        r_acc    <= n_acc;
        r_o_kind <= n_o_kind;
        r_o_rec  <= n_o_rec;
        r_o_char <= n_o_char;
        r_o_sig  <= n_o_sig;
        r_o_last <= n_o_last;
        r_o_done <= n_o_done;
        r_o_ovf  <= n_o_ovf;
    end

endmodule

`default_nettype wire

FILE: sim/slfp_table_write_checker.sv
`timescale 1ns / 100ps
// Checker of the scan list field parser: predicts the table writes of each byte
// transaction and compares them with the result channel. Depends on slfp_pkg.

module slfp_table_write_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_ready,
    input  wire logic [7:0]                         i_ch,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [slfp_pkg::ZCNT_W-1:0]        i_cfg_wr_data,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic [1:0]                         i_field_kind,
    input  wire logic [slfp_pkg::REC_W-1:0]         i_record_index,
    input  wire logic [7:0]                         i_text_char,
    input  wire logic signed [slfp_pkg::SIG_W-1:0]  i_signal_value,
    input  wire logic                               i_last,
    input  wire logic                               i_done_res,
    input  wire logic                               i_record_overflow,
    output int                                      o_pending,
    output int                                      o_fail_count,
    output int                                      o_results
);

    typedef struct packed {
        logic [1:0]                        kind;
        logic [slfp_pkg::REC_W-1:0]        rec;
        logic [7:0]                        text;
        logic signed [slfp_pkg::SIG_W-1:0] sig;
        logic                              last;
        logic                              done;
        logic                              ovf;
    } t_table_write;

    t_table_write      pending_writes[$];

    // Parser state as seen from outside
    logic [slfp_pkg::ZCNT_W-1:0] timeout_limit_q;
    logic [slfp_pkg::LINE_W-1:0] line_idx;
    logic [slfp_pkg::FLD_W-1:0]  field_idx;
    logic [7:0]                  field_buf[slfp_pkg::FIELD_CHARS];
    int                          buf_count;
    logic                        after_lf;
    logic [slfp_pkg::BLK_W-1:0]  blank_cr;
    logic [slfp_pkg::ZCNT_W-1:0] zero_count;

    int                mismatches = 0;
    int                results_seen = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: result %0d: %s", $time, results_seen, msg);
    endtask

    function automatic t_table_write table_write(input logic [1:0] kind,
                                                 input logic [7:0] text,
                                                 input logic signed [slfp_pkg::SIG_W-1:0] sig,
                                                 input logic ovf);
        t_table_write w;
        w.kind = kind;
        w.rec  = line_idx[slfp_pkg::REC_W-1:0];
        w.text = text;
        w.sig  = sig;
        w.last = 1'b0;
        w.done = 1'b0;
        w.ovf  = ovf;
        return w;
    endfunction

    // Stream the buffer up to the first stored zero, then the terminator
    function automatic void queue_string(input logic [1:0] kind);
        for (int i = 0; i < buf_count; i++) begin
            if (field_buf[i] == slfp_pkg::CH_NUL) break;
            pending_writes.push_back(table_write(kind, field_buf[i], '0, 1'b0));
        end
        pending_writes.push_back(table_write(kind, slfp_pkg::CH_NUL, '0, 1'b0));
    endfunction

    function automatic logic signed [slfp_pkg::SIG_W-1:0] field_value();
        int   i;
        int   acc;
        logic neg;
        i   = 0;
        acc = 0;
        neg = 1'b0;
        while (i < buf_count && (field_buf[i] == slfp_pkg::CH_SP ||
               field_buf[i] == slfp_pkg::CH_TAB || field_buf[i] == slfp_pkg::CH_VT ||
               field_buf[i] == slfp_pkg::CH_FF))
            i++;
        if (i < buf_count && (field_buf[i] == slfp_pkg::CH_MINUS ||
                              field_buf[i] == slfp_pkg::CH_PLUS)) begin
            neg = (field_buf[i] == slfp_pkg::CH_MINUS);
            i++;
        end
        while (i < buf_count && field_buf[i] >= slfp_pkg::CH_0 &&
               field_buf[i] <= slfp_pkg::CH_9) begin
            acc = acc * 10 + int'(field_buf[i] - slfp_pkg::CH_0);
            if (acc > 100000) acc = 100000;
            i++;
        end
        if (neg) acc = -acc;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        return acc[slfp_pkg::SIG_W-1:0];
    endfunction

    function automatic void predict_table_writes(input logic [7:0] c);
        int           first;
        logic         done_now;
        logic         commit;
        t_table_write w;
        first    = pending_writes.size();
        done_now = 1'b0;
        commit   = 1'b0;

        if (c == slfp_pkg::CH_NUL) begin
            if (zero_count != slfp_pkg::ZCNT_SAT) zero_count++;
            if (zero_count > timeout_limit_q) begin
                zero_count = '0;
                line_idx   = '0;
                buf_count  = 0;
                field_idx  = '0;
                blank_cr   = '0;
                done_now   = 1'b1;
            end
        end

        if (c == slfp_pkg::CH_COMMA) begin
            if (field_idx == slfp_pkg::FIELD_NONE) field_idx = '0;
            else if (field_idx < slfp_pkg::FIELD_TOP) field_idx = field_idx + 1'b1;
            commit = 1'b1;
        end else if (c == slfp_pkg::CH_LF) begin
            buf_count = 0;
            field_idx = slfp_pkg::FIELD_NONE;
        end else if (c == slfp_pkg::CH_CR) begin
            if (after_lf) begin
                blank_cr = blank_cr + 1'b1;
                if (blank_cr > 1) begin
                    line_idx  = '0;
                    buf_count = 0;
                    field_idx = '0;
                    blank_cr  = '0;
                    done_now  = 1'b1;
                end
            end else begin
                commit = 1'b1;
            end
        end else begin
            if (buf_count < slfp_pkg::FIELD_CHARS) begin
                field_buf[buf_count] = c;
                buf_count++;
            end
            blank_cr = '0;
        end
        after_lf = (c == slfp_pkg::CH_LF);

        if (commit && (field_idx == slfp_pkg::FIELD_NAME || field_idx == slfp_pkg::FIELD_SEC ||
                       field_idx == slfp_pkg::FIELD_SIG)) begin
            if (line_idx >= slfp_pkg::MAX_RECORDS) begin
                pending_writes.push_back(table_write(slfp_pkg::KIND_STATUS, slfp_pkg::CH_NUL,
                                                     '0, 1'b1));
            end else if (field_idx == slfp_pkg::FIELD_NAME) begin
                queue_string(slfp_pkg::KIND_NAME);
                pending_writes.push_back(table_write(slfp_pkg::KIND_SIG, slfp_pkg::CH_NUL,
                                                     slfp_pkg::SIG_BLACKLIST, 1'b0));
            end else if (field_idx == slfp_pkg::FIELD_SEC) begin
                queue_string(slfp_pkg::KIND_SEC);
            end else begin
                pending_writes.push_back(table_write(slfp_pkg::KIND_SIG, slfp_pkg::CH_NUL,
                                                     field_value(), 1'b0));
            end
        end
        if (c == slfp_pkg::CH_COMMA) buf_count = 0;

        if (pending_writes.size() == first)
            pending_writes.push_back(table_write(slfp_pkg::KIND_STATUS, slfp_pkg::CH_NUL,
                                                 '0, 1'b0));
        for (int k = first; k < pending_writes.size(); k++) begin
            w      = pending_writes[k];
            w.done = done_now;
            w.last = (k == pending_writes.size() - 1);
            pending_writes[k] = w;
        end

        if (after_lf && line_idx < slfp_pkg::MAX_RECORDS) line_idx = line_idx + 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_table_write want;
        if (!i_rst_n) begin
            timeout_limit_q = slfp_pkg::TIMEOUT_RST;
            line_idx        = '0;
            field_idx       = slfp_pkg::FIELD_NONE;
            buf_count       = 0;
            after_lf        = 1'b0;
            blank_cr        = '0;
            zero_count      = '0;
            pending_writes.delete();
        end else begin
            // Retire results first: they come from bytes taken at earlier edges
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_writes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, kind %0d", i_field_kind));
                end else begin
                    want = pending_writes.pop_front();
                    if (i_field_kind !== want.kind)
                        report_mismatch($sformatf("field_kind %0d, want %0d",
                                                  i_field_kind, want.kind));
                    if (i_record_index !== want.rec)
                        report_mismatch($sformatf("record_index %0d, want %0d",
                                                  i_record_index, want.rec));
                    if (i_text_char !== want.text)
                        report_mismatch($sformatf("text_char %02h, want %02h",
                                                  i_text_char, want.text));
                    if (i_signal_value !== want.sig)
                        report_mismatch($sformatf("signal_value %0d, want %0d",
                                                  i_signal_value, want.sig));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", i_last, want.last));
                    if (i_done_res !== want.done)
                        report_mismatch($sformatf("done_res %0b, want %0b",
                                                  i_done_res, want.done));
                    if (i_record_overflow !== want.ovf)
                        report_mismatch($sformatf("record_overflow %0b, want %0b",
                                                  i_record_overflow, want.ovf));
                end
            end
            if (i_cfg_wr_en) timeout_limit_q = i_cfg_wr_data;
            if (i_in_valid && i_in_ready) predict_table_writes(i_ch);
        end
        o_pending    <= pending_writes.size();
        o_fail_count <= mismatches;
        o_results    <= results_seen;
    end

endmodule

FILE: sim/scan_list_field_parser_test.sv
`timescale 1ns / 100ps
// Testbench top of the scan list field parser: clock, reset, byte and result
// traffic, timeout register writes and verdict. Depends on slfp_pkg,
// scan_list_field_parser and slfp_table_write_checker.

module scan_list_field_parser_test;

    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BYTES  = 40;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [7:0]                         in_ch = '0;
    logic                               cfg_wr_en = 1'b0;
    logic [slfp_pkg::ZCNT_W-1:0]        cfg_wr_data = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [1:0]                         field_kind;
    logic [slfp_pkg::REC_W-1:0]         record_index;
    logic [7:0]                         text_char;
    logic signed [slfp_pkg::SIG_W-1:0]  signal_value;
    logic                               last;
    logic                               done_res;
    logic                               record_overflow;

    int   pending;
    int   fail_count;
    int   results;
    int   bytes_sent = 0;
    int   settings_used = 0;
    int   cycles = 0;
    logic hold_go = 1'b0;   // ask the result side for one long stall
    logic send_calm = 1'b0; // sender runs back to back while set
    logic take_calm = 1'b0; // receiver runs back to back while set

    initial begin
        forever #10 clk = ~clk;
    end

    scan_list_field_parser dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (in_valid),
        .o_ready           (in_ready),
        .i_ch              (in_ch),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_wr_data     (cfg_wr_data),
        .o_valid           (out_valid),
        .i_ready           (out_ready),
        .o_field_kind      (field_kind),
        .o_record_index    (record_index),
        .o_text_char       (text_char),
        .o_signal_value    (signal_value),
        .o_last            (last),
        .o_done_res        (done_res),
        .o_record_overflow (record_overflow)
    );

    slfp_table_write_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_ch              (in_ch),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_wr_data     (cfg_wr_data),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_field_kind      (field_kind),
        .i_record_index    (record_index),
        .i_text_char       (text_char),
        .i_signal_value    (signal_value),
        .i_last            (last),
        .i_done_res        (done_res),
        .i_record_overflow (record_overflow),
        .o_pending         (pending),
        .o_fail_count      (fail_count),
        .o_results         (results)
    );

    // Watchdog: end the run if traffic stops short of the expected results
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Run stopped at the cycle limit with %0d results outstanding", pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one byte transaction. Idle a random number of cycles first, but
    // only drop valid when there is a gap, so valid never toggles within a step.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_ch    <= c;
        // Hold valid and data until the parser takes the byte
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write timeout_limit; call only with the parser drained
    task automatic set_timeout(input logic [slfp_pkg::ZCNT_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    // One field body with random content: names, numbers, raw bytes, zeros
    task automatic send_field();
        int         n;
        logic [7:0] b;
        case ($urandom_range(0, 19))
            0, 1: ;  // empty field
            2, 3, 4, 5, 6, 7: begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    b = 8'($urandom_range(8'h61, 8'h7A));
                    send_byte(b);
                end
            end
            8, 9, 10, 11, 12, 13: begin
                // Signal value: optional white space and sign, up to seven digits
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 3))
                        0: send_byte(slfp_pkg::CH_SP);
                        1: send_byte(slfp_pkg::CH_TAB);
                        2: send_byte(slfp_pkg::CH_VT);
                        default: send_byte(slfp_pkg::CH_FF);
                    endcase
                end
                if ($urandom_range(0, 2) == 0)
                    send_byte($urandom_range(0, 1) ? slfp_pkg::CH_MINUS : slfp_pkg::CH_PLUS);
                n = $urandom_range(0, 7);
                repeat (n) begin
                    b = slfp_pkg::CH_0 + 8'($urandom_range(0, 9));
                    send_byte(b);
                end
                if ($urandom_range(0, 3) == 0) send_byte(8'h64);
            end
            14, 15, 16: begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    b = 8'($urandom_range(0, 255));
                    send_byte(b);
                end
            end
            17: begin
                // Stored zero bytes cut a string short and count toward timeout
                send_byte(8'h71);
                n = $urandom_range(1, 3);
                repeat (n) send_byte(slfp_pkg::CH_NUL);
                send_byte(8'h72);
            end
            18: begin
                // Now and then overrun the field buffer
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 38) : 3;
                repeat (n) begin
                    b = 8'($urandom_range(8'h41, 8'h5A));
                    send_byte(b);
                end
            end
            default: begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    b = 8'($urandom_range(8'h20, 8'h7E));
                    send_byte(b);
                end
            end
        endcase
    endtask

    // Mostly well-formed scan records, with some raw noise
    task automatic send_record();
        int         n;
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                b = 8'($urandom_range(0, 255));
                send_byte(b);
            end
        end else begin
            n = $urandom_range(1, 7);
            for (int f = 0; f < n; f++) begin
                if (f > 0) send_byte(slfp_pkg::CH_COMMA);
                send_field();
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    send_byte(slfp_pkg::CH_CR);
                    send_byte(slfp_pkg::CH_LF);
                end
                6, 7: send_byte(slfp_pkg::CH_LF);
                8: send_byte(slfp_pkg::CH_CR);  // lone CR commits and keeps the line open
                default: begin
                    // End of reply: two blank lines that each start with CR
                    send_byte(slfp_pkg::CH_LF);
                    send_byte(slfp_pkg::CH_CR);
                    send_byte(slfp_pkg::CH_LF);
                    send_byte(slfp_pkg::CH_CR);
                end
            endcase
        end
    endtask

    task automatic send_records(input int quota);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < quota) send_record();
    endtask

    // Result side: random stalls per transaction, one long hold on request
    initial begin
        int   gap;
        logic held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
            gap = take_calm ? 0 : $urandom_range(0, 11);
            if (hold_go && !held) begin
                // Hold off long enough for the job queue to fill and stall input
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: name cut by a stored zero, skipped field, security string,
        // the same field committed again by a lone CR, end of reply, 0xFF, then
        // a zero-byte timeout with a tight limit
        set_timeout(slfp_pkg::ZCNT_W'(2));
        send_text(",A");
        send_byte(slfp_pkg::CH_NUL);
        send_text("B,x,S, 7\r\n\r\n\r");
        send_byte(8'hFF);
        send_byte(slfp_pkg::CH_NUL);
        send_byte(slfp_pkg::CH_NUL);
        drain();

        // Limit at the top: timeout never fires. Run past the table size, then
        // past the last field index.
        set_timeout(slfp_pkg::ZCNT_SAT);
        n = $urandom_range(16, 19);
        repeat (n) begin
            if ($urandom_range(0, 1)) send_byte(8'h6C);
            send_byte(slfp_pkg::CH_LF);
        end
        send_text(",N,x,S,9,\n\r\n\r");
        repeat (33) send_byte(slfp_pkg::CH_COMMA);
        send_text("\r\n");
        send_records(PHASE_BYTES);
        drain();

        // Limit at zero: every zero byte times out. Stall the result side here.
        set_timeout('0);
        hold_go <= 1'b1;
        send_records(PHASE_BYTES);
        drain();

        set_timeout(slfp_pkg::ZCNT_W'($urandom_range(1, 12)));
        send_records(PHASE_BYTES);
        drain();

        set_timeout(slfp_pkg::TIMEOUT_RST);
        send_records(PHASE_BYTES);
        drain();

        repeat (40) @(posedge clk);
        $display("Sent %0d bytes under %0d timeout settings; %0d results compared.",
                 bytes_sent, settings_used, results);
        $display("Covered names, security strings, values, end of reply, timeouts, "
                 , "table overflow and a long result stall.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/slfp_pkg.sv
src/slfp_front.sv
src/slfp_fifo.sv
src/slfp_back.sv
src/scan_list_field_parser.sv
sim/slfp_table_write_checker.sv
sim/scan_list_field_parser_test.sv
